// ===== design/gcpg_pkg.sv =====
// package with constants, register indexes and pipeline types of the gradient checker generator
package gcpg_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned COORD_W = 12;
  localparam int unsigned QUO_W   = 16;
  localparam int unsigned TQ_W    = QUO_W + 1;
  localparam int unsigned DIV_STAGES    = 4;
  localparam int unsigned STEPS_PER_STG = QUO_W / DIV_STAGES;
  localparam int unsigned CHK_STEPS     = 3;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 13;

  localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(2);
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  localparam logic [24:0] CHECK_ADD_Q16 = 25'd2088960;
  localparam logic [24:0] BYTE_MAX_Q16  = 25'(255 * 65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_RED     = 3'd0,
    REG_BASE_GREEN   = 3'd1,
    REG_BASE_BLUE    = 3'd2,
    REG_ALPHA_INNER  = 3'd3,
    REG_ALPHA_OUTER  = 3'd4,
    REG_IMAGE_WIDTH  = 3'd5,
    REG_IMAGE_HEIGHT = 3'd6
  } cfg_reg_e;

  // first stage: mirrored distance and clamped coordinate
  typedef struct packed {
    logic [DIM_W-1:0]   dsum;
    logic               sat;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } front_t;

  // divider stages: partial remainder and quotient
  typedef struct packed {
    logic [DIM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             sat;
    logic             chk;
  } div_t;

  // product stage
  typedef struct packed {
    logic [26:0] prod_r;
    logic [26:0] prod_g;
    logic [26:0] prod_b;
    logic [24:0] prod_a;
    logic        chk;
  } mul_t;

endpackage

// ===== design/gradient_checker_pixel_generator.sv =====
// gradient checker pixel generator: coordinate in, rgba pixel out
// path: front stage, four divider stages, product stage, output register; an output stall holds them all
// throughput: one pixel per cycle while the output is not stalled; the sixteen-bit fraction divider is spread over
// four stages of four restoring steps each, so nothing loops
// reset: all stage valid bits clear and config registers reset at once; stage data is not reset
// a stall on a valid output freezes the whole pipeline; no clearing pass is needed
module gradient_checker_pixel_generator
  import gcpg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic [COORD_W-1:0]    col_i,
  input  logic [COORD_W-1:0]    row_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o,
  output logic [7:0]            alpha_o
);

  // configuration registers
  logic [7:0]       base_red_q, base_green_q, base_blue_q;
  logic [7:0]       alpha_inner_q, alpha_outer_q;
  logic [DIM_W-1:0] image_width_q, image_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_red_q     <= 8'd255;
      base_green_q   <= 8'd255;
      base_blue_q    <= 8'd255;
      alpha_inner_q  <= 8'd255;
      alpha_outer_q  <= 8'd0;
      image_width_q  <= DIM_W'(64);
      image_height_q <= DIM_W'(64);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BASE_RED:     base_red_q     <= cfg_data_i[7:0];
        REG_BASE_GREEN:   base_green_q   <= cfg_data_i[7:0];
        REG_BASE_BLUE:    base_blue_q    <= cfg_data_i[7:0];
        REG_ALPHA_INNER:  alpha_inner_q  <= cfg_data_i[7:0];
        REG_ALPHA_OUTER:  alpha_outer_q  <= cfg_data_i[7:0];
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // used dimensions; the user must keep them static while requests are in flight, the block does not enforce it
  logic [DIM_W-1:0] w, h, span;
  assign w = (image_width_q < DIM_MIN) ? DIM_MIN :
             (image_width_q > DIM_MAX) ? DIM_MAX : image_width_q;
  assign h = (image_height_q < DIM_MIN) ? DIM_MIN :
             (image_height_q > DIM_MAX) ? DIM_MAX : image_height_q;
  assign span = (w >> 1) + (h >> 1);

  // one restoring step: remainder below divisor on entry and exit
  function automatic logic [DIM_W:0] div_step(input logic [DIM_W-1:0] rem,
                                              input logic [DIM_W-1:0] dvs);
    logic [DIM_W:0] dbl;
    logic [DIM_W:0] res;
    dbl = {rem, 1'b0};
    if (dbl >= {1'b0, dvs}) begin
      res = {1'b1, DIM_W'(dbl - {1'b0, dvs})};
    end else begin
      res = {1'b0, dbl[DIM_W-1:0]};
    end
    return res;
  endfunction

  // pipeline control: one global enable, the pipe only halts on a stalled full output
  logic       adv;
  logic [6:0] v_q;
  assign stall_o = v_q[6] && stall_i;
  assign adv     = !stall_o;
  assign valid_o = v_q[6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  // stage 1: clamp the coordinate, mirror it and form the distance
  front_t             front_d, front_q;
  logic [COORD_W-1:0] col_c, row_c, mx, my, w_m1, h_m1;

  always_comb begin
    w_m1  = COORD_W'(w - DIM_W'(1));
    h_m1  = COORD_W'(h - DIM_W'(1));
    col_c = (col_i > w_m1) ? w_m1 : col_i;
    row_c = (row_i > h_m1) ? h_m1 : row_i;
    // odd centre column or row mirrors onto itself
    mx = ({1'b0, col_c} < (w >> 1)) ? col_c : COORD_W'(w_m1 - col_c);
    my = ({1'b0, row_c} < (h >> 1)) ? row_c : COORD_W'(h_m1 - row_c);
    front_d.dsum = DIM_W'({mx, 1'b0}) + DIM_W'(my);
    front_d.sat  = front_d.dsum >= span;
    front_d.col  = col_c;
    front_d.row  = row_c;
  end

  always_ff @(posedge clk_i) begin
    if (adv) front_q <= front_d;
  end

  // stages 2 to 5: fraction divider, checker parity worked out in stage 2
  div_t div_d [DIV_STAGES];
  div_t div_q [DIV_STAGES];

  always_comb begin
    logic [DIM_W-1:0] cr, rr;
    logic [2:0]       cq, rq;
    logic [DIM_W:0]   st;
    cr = DIM_W'(front_q.col);
    rr = DIM_W'(front_q.row);
    cq = '0;
    rq = '0;
    // col*8/w and row*8/h, three quotient bits each
    for (int k = 0; k < CHK_STEPS; k++) begin
      st = div_step(cr, w);
      cr = st[DIM_W-1:0];
      cq = {cq[1:0], st[DIM_W]};
      st = div_step(rr, h);
      rr = st[DIM_W-1:0];
      rq = {rq[1:0], st[DIM_W]};
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        div_d[s].rem = front_q.dsum;
        div_d[s].quo = '0;
        div_d[s].sat = front_q.sat;
        div_d[s].chk = cq[0] ^ rq[0];
      end else begin
        div_d[s] = div_q[s-1];
      end
      for (int k = 0; k < STEPS_PER_STG; k++) begin
        st = div_step(div_d[s].rem, span);
        div_d[s].rem = st[DIM_W-1:0];
        div_d[s].quo = {div_d[s].quo[QUO_W-2:0], st[DIM_W]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < DIV_STAGES; s++) div_q[s] <= div_d[s];
    end
  end

  // stage 6: spans times fraction
  mul_t            mul_d, mul_q;
  logic [TQ_W-1:0] tq;
  logic [7:0]      adiff;
  logic            a_up;

  always_comb begin
    tq    = div_q[DIV_STAGES-1].sat ? TQ_W'(65536) : {1'b0, div_q[DIV_STAGES-1].quo};
    a_up  = alpha_inner_q >= alpha_outer_q;
    adiff = a_up ? (alpha_inner_q - alpha_outer_q) : (alpha_outer_q - alpha_inner_q);
    mul_d.prod_r = 27'(10'(3 * base_red_q)) * 27'(tq);
    mul_d.prod_g = 27'(10'(3 * base_green_q)) * 27'(tq);
    mul_d.prod_b = 27'(10'(3 * base_blue_q)) * 27'(tq);
    mul_d.prod_a = 25'(adiff) * 25'(tq);
    mul_d.chk    = div_q[DIV_STAGES-1].chk;
  end

  always_ff @(posedge clk_i) begin
    if (adv) mul_q <= mul_d;
  end

  // stage 7: blend, checker brightening, saturation, output register
  function automatic logic [7:0] color_out(input logic [7:0]  base,
                                           input logic [26:0] prod,
                                           input logic        chk);
    logic [24:0] v;
    v = 25'({base, 14'd0}) + 25'(prod >> 2);
    if (chk) v = v + CHECK_ADD_Q16;
    if (v > BYTE_MAX_Q16) v = BYTE_MAX_Q16;
    return v[23:16];
  endfunction

  logic [24:0] a_val;
  assign a_val = a_up ? ({1'b0, alpha_outer_q, 16'd0} + mul_q.prod_a)
                      : ({1'b0, alpha_outer_q, 16'd0} - mul_q.prod_a);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_o   <= color_out(base_red_q, mul_q.prod_r, mul_q.chk);
      green_o <= color_out(base_green_q, mul_q.prod_g, mul_q.chk);
      blue_o  <= color_out(base_blue_q, mul_q.prod_b, mul_q.chk);
      alpha_o <= a_val[23:16];
    end
  end

endmodule

// ===== design/gcpg_checker.sv =====
// port-level assertions for the gradient checker generator and their bind
module gcpg_checker
  import gcpg_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_ready_o,
  input logic                 stall_o,
  input logic                 valid_o,
  input logic                 stall_i,
  input logic [7:0]           red_o,
  input logic [7:0]           green_o,
  input logic [7:0]           blue_o,
  input logic [7:0]           alpha_o
);

  // a stalled pixel holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable({red_o, green_o, blue_o, alpha_o}))
    else $error("stalled pixel changed");

  // input side only halts behind a stalled full output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without output back-pressure");

  // output free means input free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(valid_o && stall_i) |-> !stall_o)
    else $error("input stalled with output free");

  // register port always takes writes
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("register port not ready");

endmodule

bind gradient_checker_pixel_generator gcpg_checker u_gcpg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .cfg_ready_o(cfg_ready_o),
  .stall_o    (stall_o),
  .valid_o    (valid_o),
  .stall_i    (stall_i),
  .red_o      (red_o),
  .green_o    (green_o),
  .blue_o     (blue_o),
  .alpha_o    (alpha_o)
);

// ===== tb/gcpg_pixel_checker.sv =====
// checker that predicts each pixel of the gradient checker generator and compares it
module gcpg_pixel_checker
  import gcpg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  valid_i,
  input  logic                  stall_i,
  input  logic [COORD_W-1:0]    col_i,
  input  logic [COORD_W-1:0]    row_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic [7:0]            alpha_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  logic [7:0]  shade_r, shade_g, shade_b, a_in, a_out;
  logic [12:0] img_w, img_h;
  pixel_t      pixel_q[$];

  assign pending_o = pixel_q.size();

  function automatic logic [63:0] mix(logic [63:0] edge_v, logic [63:0] centre_v,
                                      logic [63:0] frac);
    if (centre_v >= edge_v) return edge_v + (((centre_v - edge_v) * frac) >> 16);
    return edge_v - (((edge_v - centre_v) * frac) >> 16);
  endfunction

  function automatic logic [7:0] colour(logic [7:0] base, logic [63:0] frac, logic odd);
    logic [63:0] v;
    v = mix(64'(base) << 14, 64'(base) << 16, frac);
    if (odd) v = v + 64'(CHECK_ADD_Q16);
    if (v > 64'(BYTE_MAX_Q16)) v = 64'(BYTE_MAX_Q16);
    return v[23:16];
  endfunction

  function automatic pixel_t predict_pixel(logic [11:0] cin, logic [11:0] rin);
    int unsigned w, h, c, r, mx, my, odd;
    logic [63:0] dsum, frac, av;
    pixel_t p;
    w = img_w < 2 ? 2 : (img_w > MAX_DIM ? MAX_DIM : img_w);
    h = img_h < 2 ? 2 : (img_h > MAX_DIM ? MAX_DIM : img_h);
    c = cin > w - 1 ? w - 1 : cin;
    r = rin > h - 1 ? h - 1 : rin;
    mx = c < w / 2 ? c : w - 1 - c;
    my = r < h / 2 ? r : h - 1 - r;
    dsum = 2 * mx + my;
    frac = (dsum * 65536) / (w / 2 + h / 2);
    if (frac > 65536) frac = 65536;
    odd = ((c * 8 / w) + (r * 8 / h)) & 1;
    p.red   = colour(shade_r, frac, odd[0]);
    p.green = colour(shade_g, frac, odd[0]);
    p.blue  = colour(shade_b, frac, odd[0]);
    av = mix(64'(a_out) << 16, 64'(a_in) << 16, frac);
    p.alpha = av[23:16];
    return p;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    pixel_t e;
    if (!rst_ni) begin
      shade_r <= 8'd255; shade_g <= 8'd255; shade_b <= 8'd255;
      a_in <= 8'd255; a_out <= 8'd0; img_w <= 13'd64; img_h <= 13'd64;
      fail_count_o <= 0;
      pixel_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_BASE_RED:     shade_r <= cfg_data_i[7:0];
          REG_BASE_GREEN:   shade_g <= cfg_data_i[7:0];
          REG_BASE_BLUE:    shade_b <= cfg_data_i[7:0];
          REG_ALPHA_INNER:  a_in <= cfg_data_i[7:0];
          REG_ALPHA_OUTER:  a_out <= cfg_data_i[7:0];
          REG_IMAGE_WIDTH:  img_w <= cfg_data_i;
          REG_IMAGE_HEIGHT: img_h <= cfg_data_i;
          default: ;
        endcase
      end
      if (valid_i && !stall_i) pixel_q.push_back(predict_pixel(col_i, row_i));
      if (out_valid_i && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel %h %h %h %h", $time, red_i, green_i, blue_i,
                   alpha_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = pixel_q.pop_front();
          if (e != {red_i, green_i, blue_i, alpha_i}) begin
            $display("%0t: pixel mismatch expected %h %h %h %h actual %h %h %h %h", $time,
                     e.red, e.green, e.blue, e.alpha, red_i, green_i, blue_i, alpha_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_gradient_checker_pixel_generator.sv =====
// testbench top: stimulus, configuration phases and verdict for the pixel generator
module tb_gradient_checker_pixel_generator;
  import gcpg_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  valid_i = 1'b0;
  logic                  stall_o;
  logic [COORD_W-1:0]    col_i = '0;
  logic [COORD_W-1:0]    row_i = '0;
  logic                  valid_o;
  logic                  stall_i = 1'b0;
  logic [7:0]            red_o, green_o, blue_o, alpha_o;
  int                    fail_count, pending;
  int                    cycle_count = 0;
  bit                    hold_req = 1'b0;
  bit                    hold_off = 1'b0;
  bit                    stim_done = 1'b0;

  always #10 clk_i = ~clk_i;

  gradient_checker_pixel_generator uut (.*);

  gcpg_pixel_checker u_chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .valid_i, .stall_i(stall_o), .col_i, .row_i,
    .out_valid_i(valid_o), .out_stall_i(stall_i),
    .red_i(red_o), .green_i(green_o), .blue_i(blue_o), .alpha_i(alpha_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog, far beyond the slowest correct run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: own stall pattern, with a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_off) stall_i <= 1'b1;
    else if (stim_done) stall_i <= 1'b0;
    else case (cycle_count / 300 % 3)
      0: stall_i <= 1'b0;                       // free-running stretch
      1: stall_i <= ($urandom_range(0, 3) == 0);
      default: stall_i <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // long hold-off counted here, so the pipeline fills and stalls its input
  initial begin
    int n;
    wait (hold_req);
    hold_off = 1'b1;
    n = 0;
    while (n < 60) begin
      @(posedge clk_i);
      n++;
    end
    hold_off = 1'b0;
  end

  // leaves the write valid; the caller drops it after its last write
  task automatic write_reg(cfg_reg_e idx, logic [12:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_image(logic [7:0] r, g, b, ai, ao, logic [12:0] w, h);
    write_reg(REG_BASE_RED, {5'd0, r});
    write_reg(REG_BASE_GREEN, {5'd0, g});
    write_reg(REG_BASE_BLUE, {5'd0, b});
    write_reg(REG_ALPHA_INNER, {5'd0, ai});
    write_reg(REG_ALPHA_OUTER, {5'd0, ao});
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_valid_i <= 1'b0;
  endtask

  // send one pixel request, holding it until accepted; bursts with random gaps
  task automatic send_pixel(logic [11:0] c, logic [11:0] r);
    if (!hold_off && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 4)) begin
        valid_i <= 1'b0;
        @(posedge clk_i);
      end
    valid_i <= 1'b1;
    col_i   <= c;
    row_i   <= r;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // mostly in-range coordinates, some beyond the image to hit the clamp
  task automatic random_pixels(int n, int w, int h);
    int wd, ht;
    wd = w < 2 ? 2 : (w > 4096 ? 4096 : w);
    ht = h < 2 ? 2 : (h > 4096 ? 4096 : h);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) send_pixel(12'($urandom), 12'($urandom));
      else send_pixel(12'($urandom_range(0, wd - 1)), 12'($urandom_range(0, ht - 1)));
    end
  endtask

  initial begin
    int w, h;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, corners, centre, out-of-range coordinates
    send_pixel(0, 0);
    send_pixel(31, 31);
    send_pixel(32, 32);
    send_pixel(63, 63);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'hfff, 0);
    send_pixel(0, 12'hfff);
    send_pixel(12'h555, 12'haaa);
    drain();

    // odd sizes: middle column and row mirror onto themselves
    set_image(8'd0, 8'd128, 8'd77, 8'd0, 8'd255, 13'd5, 13'd7);
    send_pixel(2, 3);
    send_pixel(2, 0);
    send_pixel(0, 3);
    send_pixel(4, 6);
    drain();

    // dimension below minimum, above maximum, and an unknown register index
    set_image(8'd255, 8'd1, 8'd254, 8'd200, 8'd100, 13'd0, 13'h1fff);
    write_reg(cfg_reg_e'(3'd7), 13'h1fff);
    cfg_valid_i <= 1'b0;
    send_pixel(0, 0);
    send_pixel(1, 2048);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(1, 4095);
    drain();

    // largest image, only a few requests
    set_image(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 13'd4096, 13'd4096);
    send_pixel(2047, 2047);
    send_pixel(2048, 2048);
    send_pixel(4095, 0);
    drain();

    // random phases with random settings, small sizes mostly
    for (int phase = 0; phase < 8; phase++) begin
      w = (phase == 7) ? $urandom_range(0, 8191) : $urandom_range(0, 80);
      h = (phase == 6) ? $urandom_range(0, 8191) : $urandom_range(0, 80);
      set_image(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                13'(w), 13'(h));
      // long receiver hold-off while this phase keeps sending
      if (phase == 2) hold_req = 1'b1;
      random_pixels(50, w, h);
      drain();
    end

    stim_done = 1'b1;
    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
